// ===== design/debounced_alarm_with_siren_sweep_top_macros.svh =====
// ----------------------------------------------------------------------------
// debounced alarm with siren sweep - assertion macros
// shared concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_ALARM_WITH_SIREN_SWEEP_TOP_MACROS_SVH
`define DEBOUNCED_ALARM_WITH_SIREN_SWEEP_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DASW_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("dasw assertion failed");
// condition must never be true outside reset
`define DASW_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("dasw forbidden condition seen");
`else
`define DASW_ASSERT(label, prop)
`define DASW_NEVER(label, cond)
`endif

`endif

// ===== design/dasw_pkg.sv =====
// ----------------------------------------------------------------------------
// dasw_pkg
// widths, reset values, register map and state type of the siren alarm
// ----------------------------------------------------------------------------
`default_nettype none

package dasw_pkg;

   localparam int COUNT_W    = 7;
   localparam int FREQ_W     = 16;
   localparam int STEP_W     = 10;
   localparam int INTERVAL_W = 8;
   localparam int OUT_W      = 26;
   localparam int DEN_W      = FREQ_W + 1;
   localparam int DIV_CNT_W  = $clog2(OUT_W);
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;

   localparam logic [COUNT_W-1:0]    RST_CEILING   = COUNT_W'(100);
   localparam logic [COUNT_W-1:0]    RST_THRESHOLD = COUNT_W'(99);
   localparam logic [FREQ_W-1:0]     RST_FREQ_LOW  = FREQ_W'(5000);
   localparam logic [FREQ_W-1:0]     RST_FREQ_HIGH = FREQ_W'(15000);
   localparam logic [STEP_W-1:0]     RST_STEP      = STEP_W'(10);
   localparam logic [INTERVAL_W-1:0] RST_INTERVAL  = INTERVAL_W'(10);
   localparam logic [FREQ_W-1:0]     RST_OFFSET    = FREQ_W'(3500);
   localparam logic [OUT_W-1:0]      RST_CLOCK_HZ  = OUT_W'(16000000);

   typedef enum logic [2:0] {
      CSR_COUNT_CEILING,
      CSR_ALARM_THRESHOLD,
      CSR_FREQ_LOW,
      CSR_FREQ_HIGH,
      CSR_FREQ_STEP,
      CSR_UPDATE_INTERVAL,
      CSR_DUTY_OFFSET,
      CSR_CLOCK_HZ
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

// ===== design/dasw_if.sv =====
// ----------------------------------------------------------------------------
// dasw channel interfaces
// valid/ready channels for the tick input and the result output
// ----------------------------------------------------------------------------
`default_nettype none

interface dasw_req_if;
   logic valid;
   logic ready;
   logic wire_level;

   modport source (output valid, output wire_level, input ready);
   modport sink   (input valid, input wire_level, output ready);
endinterface

interface dasw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       alarm_active;
   logic                       report_pulse;
   logic                       pwm_load;
   logic [dasw_pkg::OUT_W-1:0] pwm_period;
   logic [dasw_pkg::OUT_W-1:0] pwm_duty;

   modport source (output valid, output alarm_active, output report_pulse,
                   output pwm_load, output pwm_period, output pwm_duty, input ready);
   modport sink   (input valid, input alarm_active, input report_pulse,
                   input pwm_load, input pwm_period, input pwm_duty, output ready);
endinterface

`default_nettype wire

// ===== design/dasw_div.sv =====
// ----------------------------------------------------------------------------
// dasw_div
// bit-serial restoring divider, one quotient bit per cycle, zero divisor
// gives an all-ones quotient
// ----------------------------------------------------------------------------
`default_nettype none

module dasw_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [dasw_pkg::OUT_W-1:0] num,
   input  wire logic [dasw_pkg::DEN_W-1:0] den,
   output logic      [dasw_pkg::OUT_W-1:0] quot,
   output logic                            done
);

   localparam int OUT_W = dasw_pkg::OUT_W;
   localparam int DEN_W = dasw_pkg::DEN_W;
   localparam int CNT_W = dasw_pkg::DIV_CNT_W;

   logic [OUT_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             fits;

   assign trial = {rem_ff, num_ff[OUT_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign fits  = ~diff[DEN_W+1];

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when the divisor fits
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in = {num_ff[OUT_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot = num_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// ===== design/debounced_alarm_with_siren_sweep_top.sv =====
// ----------------------------------------------------------------------------
// debounced_alarm_with_siren_sweep_top
// wire-break alarm with integrating debounce and a swept siren pwm setting
// ----------------------------------------------------------------------------
// Each req transaction is one timer tick carrying the sampled sense wire
// level; each tick yields exactly one rsp transaction. The debounce
// integrator, alarm flag and siren sweep state update at the edge where the
// tick is accepted. On a sweep update tick (pwm_load high) the pwm period
// clock_hz/freq and duty clock_hz/(2*freq-duty_offset) come from two
// bit-serial restoring dividers working side by side, one quotient bit per
// cycle. Such a tick goes from idle to the divide state, waits there until
// both dividers finish and then passes the deliver state, which loads the
// rsp output register once it is free; only then is the next tick taken in
// idle. A tick without an update goes from idle straight to deliver. The
// 26-bit dividend width sets the divide time. A finished result sits in the
// rsp output register, so the next tick is accepted while it waits. Config
// registers sit on the apb port at byte address 4*index, pready is tied high;
// the user must write them only while no tick is in flight; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debounced_alarm_with_siren_sweep_top_macros.svh"

module debounced_alarm_with_siren_sweep_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   dasw_req_if.sink                         req_if,
   dasw_rsp_if.source                       rsp_if,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [dasw_pkg::ADDR_W-1:0] paddr,
   input  wire logic [dasw_pkg::DATA_W-1:0] pwdata,
   output logic      [dasw_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);

   localparam int COUNT_W    = dasw_pkg::COUNT_W;
   localparam int FREQ_W     = dasw_pkg::FREQ_W;
   localparam int STEP_W     = dasw_pkg::STEP_W;
   localparam int INTERVAL_W = dasw_pkg::INTERVAL_W;
   localparam int OUT_W      = dasw_pkg::OUT_W;
   localparam int DEN_W      = dasw_pkg::DEN_W;
   localparam int DATA_W     = dasw_pkg::DATA_W;
   localparam int ADDR_W_HI  = dasw_pkg::ADDR_W - 1;

   // ---------------------------------------------------------------------
   // config registers
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0]    ceiling_ff;
   logic [COUNT_W-1:0]    threshold_ff;
   logic [FREQ_W-1:0]     freq_low_ff;
   logic [FREQ_W-1:0]     freq_high_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [FREQ_W-1:0]     offset_ff;
   logic [OUT_W-1:0]      clock_hz_ff;

   dasw_pkg::csr_index_type csr_index;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign csr_index = dasw_pkg::csr_index_type'(paddr[ADDR_W_HI:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff   <= dasw_pkg::RST_CEILING;
         threshold_ff <= dasw_pkg::RST_THRESHOLD;
         freq_low_ff  <= dasw_pkg::RST_FREQ_LOW;
         freq_high_ff <= dasw_pkg::RST_FREQ_HIGH;
         step_ff      <= dasw_pkg::RST_STEP;
         interval_ff  <= dasw_pkg::RST_INTERVAL;
         offset_ff    <= dasw_pkg::RST_OFFSET;
         clock_hz_ff  <= dasw_pkg::RST_CLOCK_HZ;
      end else if (csr_write) begin
         case (csr_index)
            dasw_pkg::CSR_COUNT_CEILING:   ceiling_ff   <= pwdata[COUNT_W-1:0];
            dasw_pkg::CSR_ALARM_THRESHOLD: threshold_ff <= pwdata[COUNT_W-1:0];
            dasw_pkg::CSR_FREQ_LOW:        freq_low_ff  <= pwdata[FREQ_W-1:0];
            dasw_pkg::CSR_FREQ_HIGH:       freq_high_ff <= pwdata[FREQ_W-1:0];
            dasw_pkg::CSR_FREQ_STEP:       step_ff      <= pwdata[STEP_W-1:0];
            dasw_pkg::CSR_UPDATE_INTERVAL: interval_ff  <= pwdata[INTERVAL_W-1:0];
            dasw_pkg::CSR_DUTY_OFFSET:     offset_ff    <= pwdata[FREQ_W-1:0];
            dasw_pkg::CSR_CLOCK_HZ:        clock_hz_ff  <= pwdata[OUT_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         dasw_pkg::CSR_COUNT_CEILING:   prdata = DATA_W'(ceiling_ff);
         dasw_pkg::CSR_ALARM_THRESHOLD: prdata = DATA_W'(threshold_ff);
         dasw_pkg::CSR_FREQ_LOW:        prdata = DATA_W'(freq_low_ff);
         dasw_pkg::CSR_FREQ_HIGH:       prdata = DATA_W'(freq_high_ff);
         dasw_pkg::CSR_FREQ_STEP:       prdata = DATA_W'(step_ff);
         dasw_pkg::CSR_UPDATE_INTERVAL: prdata = DATA_W'(interval_ff);
         dasw_pkg::CSR_DUTY_OFFSET:     prdata = DATA_W'(offset_ff);
         dasw_pkg::CSR_CLOCK_HZ:        prdata = DATA_W'(clock_hz_ff);
         default:                       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // alarm and sweep state
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  alarm_ff, alarm_in;
   logic [INTERVAL_W-1:0] ic_ff, ic_in;
   logic [FREQ_W-1:0]     freq_ff, freq_in;
   logic                  up_ff, up_in;

   // per-tick flags held until the result is delivered
   logic                  res_alarm_ff, res_report_ff, res_load_ff;
   logic                  report_in, load_in;

   logic                  accept;
   logic [INTERVAL_W:0]   ic_next;
   logic [FREQ_W:0]       freq_sum;
   logic [FREQ_W+1:0]     duty_raw;
   logic [DEN_W-1:0]      period_den, duty_den;

   dasw_pkg::state_type   state_ff, state_in;
   logic                  div_start, deliver;
   logic                  p_done, d_done;
   logic [OUT_W-1:0]      p_quot, d_quot;

   assign accept = req_if.valid & req_if.ready;

   always_comb begin
      count_in  = count_ff;
      alarm_in  = alarm_ff;
      ic_in     = ic_ff;
      freq_in   = freq_ff;
      up_in     = up_ff;
      report_in = 1'b0;
      load_in   = 1'b0;
      freq_sum  = {1'b0, freq_ff} + {{(FREQ_W + 1 - STEP_W){1'b0}}, step_ff};
      ic_next   = {1'b0, ic_ff} + (INTERVAL_W + 1)'(1);

      // integrating debounce
      if (req_if.wire_level) begin
         if (count_ff < ceiling_ff) begin
            count_in = count_ff + COUNT_W'(1);
            if (count_in >= threshold_ff && !alarm_ff) begin
               alarm_in  = 1'b1;
               report_in = 1'b1;
            end
         end
      end else if (count_ff != '0) begin
         count_in = count_ff - COUNT_W'(1);
         if (count_in == '0) begin
            alarm_in = 1'b0;
         end
      end

      // siren sweep, interval of zero behaves as one
      if (alarm_in) begin
         if (ic_next >= {1'b0, interval_ff}) begin
            ic_in   = '0;
            load_in = 1'b1;
            if (up_ff) begin
               freq_in = freq_sum[FREQ_W] ? '1 : freq_sum[FREQ_W-1:0];
               if (freq_in >= freq_high_ff) begin
                  up_in = 1'b0;
               end
            end else begin
               freq_in = (freq_ff > FREQ_W'(step_ff)) ? freq_ff - FREQ_W'(step_ff) : '0;
               if (freq_in <= freq_low_ff) begin
                  up_in = 1'b1;
               end
            end
         end else begin
            ic_in = ic_next[INTERVAL_W-1:0];
         end
      end

      // divisors, zero or negative duty divisor saturates via zero
      duty_raw   = {1'b0, freq_in, 1'b0} - {2'b00, offset_ff};
      period_den = {1'b0, freq_in};
      duty_den   = duty_raw[FREQ_W+1] ? '0 : duty_raw[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         alarm_ff <= 1'b0;
         ic_ff    <= '0;
         freq_ff  <= dasw_pkg::RST_FREQ_LOW;
         up_ff    <= 1'b1;
      end else if (accept) begin
         count_ff <= count_in;
         alarm_ff <= alarm_in;
         ic_ff    <= ic_in;
         freq_ff  <= freq_in;
         up_ff    <= up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_alarm_ff  <= alarm_in;
         res_report_ff <= report_in;
         res_load_ff   <= load_in;
      end
   end

   // ---------------------------------------------------------------------
   // dividers for period and duty
   // ---------------------------------------------------------------------
   dasw_div u_period_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (clock_hz_ff),
      .den   (period_den),
      .quot  (p_quot),
      .done  (p_done)
   );

   dasw_div u_duty_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (clock_hz_ff),
      .den   (duty_den),
      .quot  (d_quot),
      .done  (d_done)
   );

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = ~rsp_valid_ff | rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dasw_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = load_in ? dasw_pkg::ST_DIVIDE : dasw_pkg::ST_DELIVER;
            end
         end
         dasw_pkg::ST_DIVIDE: begin
            if (p_done) begin
               state_in = dasw_pkg::ST_DELIVER;
            end
         end
         dasw_pkg::ST_DELIVER: begin
            if (out_free) begin
               state_in = dasw_pkg::ST_IDLE;
            end
         end
         default: state_in = dasw_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_if.ready = 1'b0;
      div_start    = 1'b0;
      deliver      = 1'b0;
      case (state_ff)
         dasw_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            div_start    = req_if.valid & load_in;
         end
         dasw_pkg::ST_DIVIDE: ;
         dasw_pkg::ST_DELIVER: begin
            deliver = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dasw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // result output register
   // ---------------------------------------------------------------------
   logic             out_alarm_ff, out_report_ff, out_load_ff;
   logic [OUT_W-1:0] out_period_ff, out_duty_ff;

   assign rsp_valid_in = deliver | (rsp_valid_ff & ~rsp_if.ready);

   always_ff @(posedge clock) begin
      if (deliver) begin
         out_alarm_ff  <= res_alarm_ff;
         out_report_ff <= res_report_ff;
         out_load_ff   <= res_load_ff;
         out_period_ff <= res_load_ff ? p_quot : '0;
         out_duty_ff   <= res_load_ff ? d_quot : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.alarm_active = out_alarm_ff;
   assign rsp_if.report_pulse = out_report_ff;
   assign rsp_if.pwm_load     = out_load_ff;
   assign rsp_if.pwm_period   = out_period_ff;
   assign rsp_if.pwm_duty     = out_duty_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a report only comes with the alarm raised
   `DASW_ASSERT(a_report_has_alarm, rsp_if.valid && rsp_if.report_pulse |-> rsp_if.alarm_active)
   // a raised alarm never coexists with an empty integrator
   `DASW_NEVER(a_alarm_count_zero, alarm_ff && count_ff == '0)
   // both dividers finish together and only while the sequencer waits on them
   `DASW_ASSERT(a_div_lockstep, p_done |-> d_done && state_ff == dasw_pkg::ST_DIVIDE)
   // a divide start leads to the divide state
   `DASW_ASSERT(a_start_divides, div_start |=> state_ff == dasw_pkg::ST_DIVIDE)

endmodule

`default_nettype wire

// ===== tb/tb_debounced_alarm_with_siren_sweep_top.sv =====
// ----------------------------------------------------------------------------
// tb_debounced_alarm_with_siren_sweep_top
// self-checking bench for the debounced wire-break alarm and siren sweep
// ----------------------------------------------------------------------------
// Ticks go in on the req channel and every tick yields one rsp transaction.
// A scoreboard object carries its own copy of the debounce integrator, the
// alarm flag, the sweep state and the register file. It works out the
// expected result of each accepted tick and checks the rsp transactions in
// order. Registers are written over the apb port between phases, while the
// block is idle, and each write is read back. A short directed part hits
// the report pulse, the hold at the ceiling, the alarm clear, a threshold
// above the ceiling, the turns at both sweep bounds, the frequency floor of
// zero and the saturated period and duty. Random bursts of broken-wire
// ticks follow under several register settings, with idle cycles on both
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_debounced_alarm_with_siren_sweep_top;

   timeunit 1ns;
   timeprecision 1ps;

   import dasw_pkg::*;

   // slowest run: ~575 ticks, each with a full divide plus gaps and long rsp
   // stalls, plus the apb writes and reads of every setting; this is many times that
   localparam int CYCLE_LIMIT  = 400000;
   // tick counts at which the idle pattern changes
   localparam int IDLE_SWAP_AT = 190;
   localparam int QUIET_AT     = 380;

   localparam bit [OUT_W-1:0]  OUT_MAX  = '1;
   localparam bit [FREQ_W-1:0] FREQ_MAX = '1;

   typedef struct packed {
      logic             alarm_active;
      logic             report_pulse;
      logic             pwm_load;
      logic [OUT_W-1:0] pwm_period;
      logic [OUT_W-1:0] pwm_duty;
   } siren_result_type;

   // -------------------------------------------------------------------------
   // scoreboard: alarm and sweep predictor plus the queue of awaited results
   // -------------------------------------------------------------------------
   class alarm_scoreboard;
      // register file
      bit [COUNT_W-1:0]    ceiling;
      bit [COUNT_W-1:0]    threshold;
      bit [FREQ_W-1:0]     freq_low;
      bit [FREQ_W-1:0]     freq_high;
      bit [STEP_W-1:0]     freq_step;
      bit [INTERVAL_W-1:0] update_interval;
      bit [FREQ_W-1:0]     duty_offset;
      bit [OUT_W-1:0]      clock_hz;
      // alarm and sweep state
      bit [COUNT_W-1:0]    integrator;
      bit                  alarm;
      bit [INTERVAL_W-1:0] ticks_since_update;
      bit [FREQ_W-1:0]     siren_freq;
      bit                  sweeping_up;

      siren_result_type    awaited_results[$];
      int                  mismatches;
      int                  results_seen;
      int                  reports_seen;
      int                  updates_seen;

      function new();
         ceiling            = RST_CEILING;
         threshold          = RST_THRESHOLD;
         freq_low           = RST_FREQ_LOW;
         freq_high          = RST_FREQ_HIGH;
         freq_step          = RST_STEP;
         update_interval    = RST_INTERVAL;
         duty_offset        = RST_OFFSET;
         clock_hz           = RST_CLOCK_HZ;
         integrator         = '0;
         alarm              = 1'b0;
         ticks_since_update = '0;
         siren_freq         = RST_FREQ_LOW;
         sweeping_up        = 1'b1;
      endfunction

      function void write_reg(csr_index_type idx, bit [DATA_W-1:0] value);
         case (idx)
            CSR_COUNT_CEILING:   ceiling         = value[COUNT_W-1:0];
            CSR_ALARM_THRESHOLD: threshold       = value[COUNT_W-1:0];
            CSR_FREQ_LOW:        freq_low        = value[FREQ_W-1:0];
            CSR_FREQ_HIGH:       freq_high       = value[FREQ_W-1:0];
            CSR_FREQ_STEP:       freq_step       = value[STEP_W-1:0];
            CSR_UPDATE_INTERVAL: update_interval = value[INTERVAL_W-1:0];
            CSR_DUTY_OFFSET:     duty_offset     = value[FREQ_W-1:0];
            CSR_CLOCK_HZ:        clock_hz        = value[OUT_W-1:0];
            default: ;
         endcase
      endfunction

      function bit [DATA_W-1:0] reg_value(csr_index_type idx);
         case (idx)
            CSR_COUNT_CEILING:   return DATA_W'(ceiling);
            CSR_ALARM_THRESHOLD: return DATA_W'(threshold);
            CSR_FREQ_LOW:        return DATA_W'(freq_low);
            CSR_FREQ_HIGH:       return DATA_W'(freq_high);
            CSR_FREQ_STEP:       return DATA_W'(freq_step);
            CSR_UPDATE_INTERVAL: return DATA_W'(update_interval);
            CSR_DUTY_OFFSET:     return DATA_W'(duty_offset);
            CSR_CLOCK_HZ:        return DATA_W'(clock_hz);
            default:             return '0;
         endcase
      endfunction

      // zero or negative divisor saturates
      function bit [OUT_W-1:0] sat_quotient(bit [OUT_W-1:0] num, longint den);
         longint q;
         if (den <= 0)
            return OUT_MAX;
         q = longint'(num) / den;
         return (q > longint'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
      endfunction

      function void predict_tick(bit level);
         siren_result_type r;
         int unsigned      next_count;
         int unsigned      raised;
         r = '0;
         // integrating debounce: holds at the ceiling and at zero
         if (level) begin
            if (integrator < ceiling) begin
               integrator++;
               if (integrator >= threshold && !alarm) begin
                  alarm = 1'b1;
                  r.report_pulse = 1'b1;
               end
            end
         end else if (integrator > 0) begin
            integrator--;
            if (integrator == 0)
               alarm = 1'b0;
         end
         // sweep only moves while the alarm is up
         if (alarm) begin
            next_count = ticks_since_update + 1;
            if (next_count >= update_interval) begin
               ticks_since_update = '0;
               r.pwm_load = 1'b1;
               if (sweeping_up) begin
                  raised = siren_freq + freq_step;
                  siren_freq = (raised > FREQ_MAX) ? FREQ_MAX : raised[FREQ_W-1:0];
                  if (siren_freq >= freq_high)
                     sweeping_up = 1'b0;
               end else begin
                  siren_freq = (siren_freq > freq_step) ? siren_freq - freq_step : '0;
                  if (siren_freq <= freq_low)
                     sweeping_up = 1'b1;
               end
               r.pwm_period = sat_quotient(clock_hz, longint'(siren_freq));
               r.pwm_duty   = sat_quotient(clock_hz,
                                 2 * longint'(siren_freq) - longint'(duty_offset));
            end else begin
               ticks_since_update = next_count[INTERVAL_W-1:0];
            end
         end
         r.alarm_active = alarm;
         awaited_results.push_back(r);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t (result %0d): %s", $realtime, results_seen, what);
      endtask

      task check_result(siren_result_type got);
         siren_result_type want;
         results_seen++;
         if (got.report_pulse === 1'b1)
            reports_seen++;
         if (got.pwm_load === 1'b1)
            updates_seen++;
         if (awaited_results.size() == 0) begin
            report_mismatch("result with no tick waiting for it");
            return;
         end
         want = awaited_results.pop_front();
         if (got.alarm_active !== want.alarm_active)
            report_mismatch($sformatf("alarm_active %b, expected %b",
                                      got.alarm_active, want.alarm_active));
         if (got.report_pulse !== want.report_pulse)
            report_mismatch($sformatf("report_pulse %b, expected %b",
                                      got.report_pulse, want.report_pulse));
         if (got.pwm_load !== want.pwm_load)
            report_mismatch($sformatf("pwm_load %b, expected %b",
                                      got.pwm_load, want.pwm_load));
         if (got.pwm_period !== want.pwm_period)
            report_mismatch($sformatf("pwm_period %0d, expected %0d",
                                      got.pwm_period, want.pwm_period));
         if (got.pwm_duty !== want.pwm_duty)
            report_mismatch($sformatf("pwm_duty %0d, expected %0d",
                                      got.pwm_duty, want.pwm_duty));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, channels and the block
   // -------------------------------------------------------------------------
   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   dasw_req_if req_ch ();
   dasw_rsp_if rsp_ch ();

   debounced_alarm_with_siren_sweep_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   alarm_scoreboard sb;
   int send_idle_pct = 19;   // percent of cycles the tick source holds back
   int recv_idle_pct = 49;   // percent of cycles the result sink stalls
   int ticks_sent;
   int settings_applied;
   int cycle_count;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run guard: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("debounced_alarm_with_siren_sweep_top verification failed");
         $finish;
      end
   end

   // result sink stalls at random, changing only on the falling edge
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // monitor: both handshakes sampled at the rising edge, before the block's
   // registers move; a tick and its own result never share an edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            sb.predict_tick(req_ch.wire_level);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result('{rsp_ch.alarm_active, rsp_ch.report_pulse,
                              rsp_ch.pwm_load, rsp_ch.pwm_period, rsp_ch.pwm_duty});
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------

   // one apb transaction: setup cycle, access cycle, then back to idle;
   // a read is checked against the register file of the scoreboard
   task automatic csr_access(csr_index_type idx, bit [DATA_W-1:0] value, bit is_write);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (is_write)
         sb.write_reg(idx, value);
      else if (prdata !== sb.reg_value(idx))
         sb.report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                      idx.name(), prdata, sb.reg_value(idx)));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // new register setting, applied only once every result is back
   task automatic configure(int ceil, int thr, int lo, int hi, int step, int interval,
                            int offset, int clk);
      bit [DATA_W-1:0] setting [8];
      csr_index_type   idx;
      req_ch.valid <= 1'b0;
      while (sb.awaited_results.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
      setting[CSR_COUNT_CEILING]   = ceil;
      setting[CSR_ALARM_THRESHOLD] = thr;
      setting[CSR_FREQ_LOW]        = lo;
      setting[CSR_FREQ_HIGH]       = hi;
      setting[CSR_FREQ_STEP]       = step;
      setting[CSR_UPDATE_INTERVAL] = interval;
      setting[CSR_DUTY_OFFSET]     = offset;
      setting[CSR_CLOCK_HZ]        = clk;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_access(idx, setting[idx], 1'b1);
         csr_access(idx, '0, 1'b0);
         idx = idx.next();
      end
      settings_applied++;
   endtask

   // one tick; starts and ends on a falling edge, valid left high so that
   // back-to-back ticks need no second assignment in one step
   task automatic send_tick(bit level);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.wire_level <= level;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      ticks_sent++;
      // idle pattern: source light and sink heavy, then swapped, then none
      if (ticks_sent == IDLE_SWAP_AT) begin
         send_idle_pct = 49;
         recv_idle_pct = 19;
      end else if (ticks_sent == QUIET_AT) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      @(negedge clock);
   endtask

   task automatic send_run(bit level, int count);
      repeat (count) send_tick(level);
   endtask

   // mostly well-formed breaks: a run of high ticks past the threshold,
   // then enough low ticks to clear; the rest are short broken runs and noise
   task automatic run_bursts(int items);
      int left;
      int highs;
      int lows;
      int kind;
      left = items;
      while (left > 0) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            highs = sb.threshold + $urandom_range(0, sb.ceiling / 2 + 3);
            lows  = sb.ceiling + $urandom_range(0, 2);
         end else if (kind == 7) begin
            highs = $urandom_range(1, sb.threshold);
            lows  = $urandom_range(1, sb.ceiling);
         end else begin
            highs = 0;
            lows  = 0;
            repeat ($urandom_range(1, 8)) begin
               if (left > 0) begin
                  send_tick($urandom_range(0, 1));
                  left--;
               end
            end
         end
         while (highs > 0 && left > 0) begin
            send_tick(1'b1);
            highs--;
            left--;
         end
         while (lows > 0 && left > 0) begin
            send_tick(1'b0);
            lows--;
            left--;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      int ceil;
      int thr;
      int lo;
      int hi;
      sb = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.wire_level = 1'b0;
      rsp_ch.ready      = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // narrow sweep around the start frequency, update on every alarm tick:
      // report at the threshold, hold at the ceiling, turns at both bounds,
      // duty divisor negative, then the alarm clears on the way down
      configure(4, 2, 4990, 5030, 20, 1, 65535, 67108863);
      send_run(1'b1, 6);
      send_run(1'b0, 4);

      // threshold above the ceiling: alarm must stay quiet
      configure(3, 5, 4990, 5030, 20, 1, 65535, 67108863);
      send_run(1'b1, 4);
      send_run(1'b0, 1);

      // big step down to the zero floor: period and duty divisors of zero,
      // tiny clock so the other quotients come out zero
      configure(1, 1, 100, 100, 1023, 1, 0, 1);
      send_run(1'b1, 7);
      send_run(1'b0, 1);

      // power-on setting, written back explicitly
      configure(int'(RST_CEILING), int'(RST_THRESHOLD), int'(RST_FREQ_LOW),
                int'(RST_FREQ_HIGH), int'(RST_STEP), int'(RST_INTERVAL),
                int'(RST_OFFSET), int'(RST_CLOCK_HZ));
      run_bursts(150);

      // upper extremes: widest integrator, sweep pinned at the top bound
      configure(127, 1, 65535, 65535, 1023, 1, 65535, 67108863);
      run_bursts(80);

      // lower extremes with the longest update interval
      configure(1, 1, 100, 100, 1, 255, 0, 1);
      run_bursts(60);

      // random settings, mostly short integrators so alarms come often
      repeat (5) begin
         ceil = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 127) : $urandom_range(1, 12);
         thr  = ($urandom_range(0, 5) == 0) ? $urandom_range(ceil, 127) : $urandom_range(1, ceil);
         if ($urandom_range(0, 1)) begin
            lo = $urandom_range(100, 65535);
            hi = $urandom_range(100, 65535);
         end else begin
            lo = $urandom_range(100, 20000);
            hi = lo + $urandom_range(0, 3000);
         end
         configure(ceil, thr, lo, hi, $urandom_range(1, 1023),
                   $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 255),
                   $urandom_range(0, 65535), $urandom_range(1, 67108863));
         run_bursts(52);
      end

      // drain: every result back, then the block is left quiet before the summary
      req_ch.valid <= 1'b0;
      while (sb.awaited_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      $display("%0d ticks under %0d register settings, %0d results checked",
               ticks_sent, settings_applied, sb.results_seen);
      $display("%0d alarm reports and %0d siren updates seen, %0d mismatches",
               sb.reports_seen, sb.updates_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
         $display("debounced_alarm_with_siren_sweep_top verification clean");
      end else begin
         $display("debounced_alarm_with_siren_sweep_top verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== debounced_alarm_with_siren_sweep_top.f =====
+incdir+design
design/dasw_pkg.sv
design/dasw_if.sv
design/dasw_div.sv
design/debounced_alarm_with_siren_sweep_top.sv
tb/tb_debounced_alarm_with_siren_sweep_top.sv
